/* rtl/tsc_pkg.sv */
// Shared constants, widths and payload types for the Taylor sine/cosine unit.
// No dependencies; every other file in the block but tsc_cdiv refers to this package.
`timescale 1ns / 1ps

package tsc_pkg;

  localparam int ANGLE_W = 32;
  localparam int OUT_W   = 18;

  localparam int PI_W     = 34;
  localparam int TWO_PI_W = 35;
  localparam logic [PI_W-1:0]     PI_Q32     = 34'd13493037705;
  localparam logic [TWO_PI_W-1:0] TWO_PI_Q32 = 35'd26986075409;

  localparam int WFRAC  = 24;
  localparam int Q_DROP = 32 - WFRAC;
  localparam logic [63:0] RND_HALF = 64'd1 << (WFRAC - 1);

  localparam int A_W  = PI_W - Q_DROP;
  localparam int A2_W = 28;
  localparam int A3_W = 29;
  localparam int A4_W = 31;
  localparam int A5_W = 33;
  localparam int A6_W = 34;
  localparam int A7_W = 36;

  localparam int DIV3 = 6;
  localparam int DIV4 = 24;
  localparam int DIV5 = 120;
  localparam int DIV6 = 720;
  localparam int DIV7 = 5040;

  localparam int SUM_W   = 30;
  localparam int OUT_RND = 128;
  localparam int OUT_SHR = 8;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sh1FFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 18'sh20000;

  typedef struct packed {
    logic           neg;
    logic [A_W-1:0] mag;
  } tsc_arg_t;

  typedef struct packed {
    logic            neg;
    logic [A_W-1:0]  a;
    logic [A2_W-1:0] a2;
    logic [A3_W-1:0] a3;
    logic [A4_W-1:0] a4;
    logic [A5_W-1:0] a5;
    logic [A6_W-1:0] a6;
    logic [A7_W-1:0] a7;
  } tsc_pow_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] sine;
    logic signed [OUT_W-1:0] cosine;
  } tsc_trig_t;

endpackage

/* rtl/tsc_angle_if.sv */
// Input channel of the Taylor sine/cosine unit: one angle per beat.
// Depends on tsc_pkg for the angle width.
`timescale 1ns / 1ps

interface tsc_angle_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tsc_pkg::ANGLE_W-1:0]   angle;

  modport source (output valid, output angle, input ready);
  modport sink (input valid, input angle, output ready);
endinterface

/* rtl/tsc_trig_if.sv */
// Result channel of the Taylor sine/cosine unit: sine and cosine per beat.
// Depends on tsc_pkg for the result width.
`timescale 1ns / 1ps

interface tsc_trig_if;
  logic                               valid;
  logic                               ready;
  logic signed [tsc_pkg::OUT_W-1:0]   sine;
  logic signed [tsc_pkg::OUT_W-1:0]   cosine;

  modport source (output valid, output sine, output cosine, input ready);
  modport sink (input valid, input sine, input cosine, output ready);
endinterface

/* rtl/tsc_reduce.sv */
// Angle reduction pipeline: remainder by 2*pi from a reciprocal multiply and one
// correcting subtract, then fold into [-pi, pi] and rounding of the magnitude to Q.24.
// Depends on tsc_pkg.
`timescale 1ns / 1ps

module tsc_reduce #(
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_vld,
  input  logic signed [tsc_pkg::ANGLE_W-1:0]  angle,
  output logic                                out_vld,
  output tsc_pkg::tsc_arg_t                   out_arg
);

  localparam int AW    = tsc_pkg::ANGLE_W;
  localparam int SHIFT = AW - ANGLE_FRAC_BITS;
  localparam int RW    = tsc_pkg::TWO_PI_W;
  localparam int PW    = tsc_pkg::PI_W;
  localparam int DW    = RW + 1;
  localparam int QW    = SHIFT - 1;
  localparam int MW    = AW + QW;
  localparam int TW    = QW + RW;
  localparam logic [63:0]   RCP64    = (64'd1 << (SHIFT + AW)) / 64'(tsc_pkg::TWO_PI_Q32);
  localparam logic [QW-1:0] RCP      = RCP64[QW-1:0];
  localparam logic [DW-1:0] TWO_PI_D = DW'(tsc_pkg::TWO_PI_Q32);

  logic [AW-1:0] mag_in;
  logic [AW-1:0] mag0;
  logic [AW-1:0] mag1;
  logic [AW-1:0] mag2;
  logic          sgn0;
  logic          sgn1;
  logic          sgn2;
  logic          sgn3;
  logic          sgn4;
  logic          vld0;
  logic          vld1;
  logic          vld2;
  logic          vld3;
  logic          vld4;
  logic [MW-1:0] prod;
  logic [TW-1:0] qt_full;
  logic [DW-1:0] qt;
  logic [DW-1:0] diff;
  logic [DW-1:0] diff_sub;
  logic [RW-1:0] r_low;
  logic          gt_pi;
  logic [RW-1:0] fold_wide;
  logic [PW-1:0] fold_mag;
  logic          fold_neg;
  logic          fold_vld;
  logic [PW-1:0] rnd_sum;

  assign mag_in    = angle[AW-1] ? AW'(-angle) : AW'(angle);
  assign qt_full   = TW'(prod[MW-1:AW]) * TW'(tsc_pkg::TWO_PI_Q32);
  assign diff_sub  = diff - TWO_PI_D;
  assign gt_pi     = r_low > RW'(tsc_pkg::PI_Q32);
  assign fold_wide = gt_pi ? tsc_pkg::TWO_PI_Q32 - r_low : r_low;
  assign rnd_sum   = fold_mag + PW'(1 << (tsc_pkg::Q_DROP - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0     <= 1'b0;
      vld1     <= 1'b0;
      vld2     <= 1'b0;
      vld3     <= 1'b0;
      vld4     <= 1'b0;
      fold_vld <= 1'b0;
      out_vld  <= 1'b0;
    end else if (en) begin
      vld0     <= in_vld;
      vld1     <= vld0;
      vld2     <= vld1;
      vld3     <= vld2;
      vld4     <= vld3;
      fold_vld <= vld4;
      out_vld  <= fold_vld;
    end
    if (en) begin
      mag0 <= mag_in;
      sgn0 <= angle[AW-1];

      prod <= MW'(mag0) * MW'(RCP);
      mag1 <= mag0;
      sgn1 <= sgn0;

      qt   <= qt_full[DW-1:0];
      mag2 <= mag1;
      sgn2 <= sgn1;

      diff <= DW'({mag2, {SHIFT{1'b0}}}) - qt;
      sgn3 <= sgn2;

      r_low <= (diff >= TWO_PI_D) ? diff_sub[RW-1:0] : diff[RW-1:0];
      sgn4  <= sgn3;

      fold_mag    <= fold_wide[PW-1:0];
      fold_neg    <= sgn4 ^ gt_pi;
      out_arg.neg <= fold_neg;
      out_arg.mag <= rnd_sum[PW-1:tsc_pkg::Q_DROP];
    end
  end

endmodule

/* rtl/tsc_powers.sv */
// Power chain a^2 .. a^7 of the folded magnitude in Q.24, four multiply stages,
// each product rounded half up before it is registered. Depends on tsc_pkg.
`timescale 1ns / 1ps

module tsc_powers (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  tsc_pkg::tsc_arg_t  in_arg,
  output logic               out_vld,
  output tsc_pkg::tsc_pow_t  out_pow
);

  localparam int F   = tsc_pkg::WFRAC;
  localparam int AW  = tsc_pkg::A_W;
  localparam int A2W = tsc_pkg::A2_W;
  localparam int A3W = tsc_pkg::A3_W;
  localparam int A4W = tsc_pkg::A4_W;
  localparam int A5W = tsc_pkg::A5_W;
  localparam int A6W = tsc_pkg::A6_W;
  localparam int A7W = tsc_pkg::A7_W;
  localparam int M2W = AW + AW;
  localparam int M3W = A2W + AW;
  localparam int M4W = A2W + A2W;
  localparam int M5W = A3W + A2W;
  localparam int M6W = A4W + A2W;
  localparam int M7W = A5W + A2W;

  tsc_pkg::tsc_pow_t p1, p2, p3;
  tsc_pkg::tsc_pow_t p1_next, p2_next, p3_next, pow_next;
  logic              v1, v2, v3;

  logic [M2W-1:0] m2;
  logic [M3W-1:0] m3;
  logic [M4W-1:0] m4;
  logic [M5W-1:0] m5;
  logic [M6W-1:0] m6;
  logic [M7W-1:0] m7;

  assign m2 = M2W'(in_arg.mag) * M2W'(in_arg.mag) + M2W'(tsc_pkg::RND_HALF);
  assign m3 = M3W'(p1.a2) * M3W'(p1.a) + M3W'(tsc_pkg::RND_HALF);
  assign m4 = M4W'(p1.a2) * M4W'(p1.a2) + M4W'(tsc_pkg::RND_HALF);
  assign m5 = M5W'(p2.a3) * M5W'(p2.a2) + M5W'(tsc_pkg::RND_HALF);
  assign m6 = M6W'(p2.a4) * M6W'(p2.a2) + M6W'(tsc_pkg::RND_HALF);
  assign m7 = M7W'(p3.a5) * M7W'(p3.a2) + M7W'(tsc_pkg::RND_HALF);

  always_comb begin
    p1_next     = '0;
    p1_next.neg = in_arg.neg;
    p1_next.a   = in_arg.mag;
    p1_next.a2  = m2[F+A2W-1:F];

    p2_next     = p1;
    p2_next.a3  = m3[F+A3W-1:F];
    p2_next.a4  = m4[F+A4W-1:F];

    p3_next     = p2;
    p3_next.a5  = m5[F+A5W-1:F];
    p3_next.a6  = m6[F+A6W-1:F];

    pow_next    = p3;
    pow_next.a7 = m7[F+A7W-1:F];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      v1      <= in_vld;
      v2      <= v1;
      v3      <= v2;
      out_vld <= v3;
    end
    if (en) begin
      p1      <= p1_next;
      p2      <= p2_next;
      p3      <= p3_next;
      out_pow <= pow_next;
    end
  end

endmodule

/* rtl/tsc_cdiv.sv */
// Rounded division by a constant: add half the divisor, multiply by the reciprocal,
// then one compare-and-correct step. Three stages. Depends on nothing.
`timescale 1ns / 1ps

module tsc_cdiv #(
  parameter int W   = 36,
  parameter int DIV = 5040
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [W-1:0]            num,
  output logic [W-$clog2(DIV):0]  quo
);

  localparam int QW = W - $clog2(DIV) + 1;
  localparam int PW = W + QW;
  localparam logic [63:0]   RCP64 = (64'd1 << W) / 64'(DIV);
  localparam logic [QW-1:0] RCP   = RCP64[QW-1:0];
  localparam logic [W-1:0]  HALF  = W'(DIV / 2);
  localparam logic [W-1:0]  DIVW  = W'(DIV);

  logic [W-1:0]  n1;
  logic [W-1:0]  n2;
  logic [PW-1:0] prod;
  logic [QW-1:0] q_est;
  logic [W-1:0]  rem;

  assign q_est = prod[PW-1:W];
  assign rem   = n2 - W'(q_est) * DIVW;

  always_ff @(posedge clk) begin
    if (en) begin
      n1   <= num + HALF;
      prod <= PW'(n1) * PW'(RCP);
      n2   <= n1;
      quo  <= q_est + QW'(rem >= DIVW);
    end
  end

endmodule

/* rtl/tsc_series.sv */
// Series sums for sine and cosine from the power chain, rounding to Q.16 half away
// from zero and saturation to 18 bits. Depends on tsc_pkg and tsc_cdiv.
`timescale 1ns / 1ps

module tsc_series (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  tsc_pkg::tsc_pow_t  in_pow,
  output logic               out_vld,
  output tsc_pkg::tsc_trig_t out_trig
);

  localparam int AW    = tsc_pkg::A_W;
  localparam int A2W   = tsc_pkg::A2_W;
  localparam int H2W   = A2W - 1;
  localparam int SW    = tsc_pkg::SUM_W;
  localparam int MW    = SW - 1;
  localparam int SHR   = tsc_pkg::OUT_SHR;
  localparam int RNDW  = MW - SHR;
  localparam int OW    = tsc_pkg::OUT_W;
  localparam int Q3W   = tsc_pkg::A3_W - $clog2(tsc_pkg::DIV3) + 1;
  localparam int Q4W   = tsc_pkg::A4_W - $clog2(tsc_pkg::DIV4) + 1;
  localparam int Q5W   = tsc_pkg::A5_W - $clog2(tsc_pkg::DIV5) + 1;
  localparam int Q6W   = tsc_pkg::A6_W - $clog2(tsc_pkg::DIV6) + 1;
  localparam int Q7W   = tsc_pkg::A7_W - $clog2(tsc_pkg::DIV7) + 1;
  localparam logic [SW-1:0]   ONE_Q24 = SW'(1) << tsc_pkg::WFRAC;
  localparam logic [RNDW-1:0] POS_LIM = RNDW'(131071);
  localparam logic [RNDW-1:0] NEG_LIM = RNDW'(131072);

  typedef struct packed {
    logic           neg;
    logic [AW-1:0]  a;
    logic [H2W-1:0] h2;
  } ser_lag_t;

  function automatic logic signed [OW-1:0] sat_out(input logic neg, input logic [RNDW-1:0] r);
    logic signed [OW-1:0] res;
    if (neg) begin
      res = (r > NEG_LIM) ? tsc_pkg::OUT_MIN : OW'(OW'(0) - r[OW-1:0]);
    end else begin
      res = (r > POS_LIM) ? tsc_pkg::OUT_MAX : r[OW-1:0];
    end
    return res;
  endfunction

  logic [Q3W-1:0] q3;
  logic [Q4W-1:0] q4;
  logic [Q5W-1:0] q5;
  logic [Q6W-1:0] q6;
  logic [Q7W-1:0] q7;

  tsc_cdiv #(.W(tsc_pkg::A3_W), .DIV(tsc_pkg::DIV3)) u_div3 (
    .clk(clk), .en(en), .num(in_pow.a3), .quo(q3)
  );
  tsc_cdiv #(.W(tsc_pkg::A4_W), .DIV(tsc_pkg::DIV4)) u_div4 (
    .clk(clk), .en(en), .num(in_pow.a4), .quo(q4)
  );
  tsc_cdiv #(.W(tsc_pkg::A5_W), .DIV(tsc_pkg::DIV5)) u_div5 (
    .clk(clk), .en(en), .num(in_pow.a5), .quo(q5)
  );
  tsc_cdiv #(.W(tsc_pkg::A6_W), .DIV(tsc_pkg::DIV6)) u_div6 (
    .clk(clk), .en(en), .num(in_pow.a6), .quo(q6)
  );
  tsc_cdiv #(.W(tsc_pkg::A7_W), .DIV(tsc_pkg::DIV7)) u_div7 (
    .clk(clk), .en(en), .num(in_pow.a7), .quo(q7)
  );

  ser_lag_t d1, d2, d3;
  logic     v1, v2, v3, v4, v5;

  logic [A2W-1:0] h2_sum;
  assign h2_sum = in_pow.a2 + A2W'(1);

  logic signed [SW-1:0] s_sum;
  logic signed [SW-1:0] c_sum;
  logic                 s4_neg;
  logic                 s_neg;
  logic                 c_neg;
  logic [MW-1:0]        s_mag;
  logic [MW-1:0]        c_mag;
  logic [MW-1:0]        s_rnd;
  logic [MW-1:0]        c_rnd;

  assign s_rnd = s_mag + MW'(tsc_pkg::OUT_RND);
  assign c_rnd = c_mag + MW'(tsc_pkg::OUT_RND);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      v4      <= 1'b0;
      v5      <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      v1      <= in_vld;
      v2      <= v1;
      v3      <= v2;
      v4      <= v3;
      v5      <= v4;
      out_vld <= v5;
    end
    if (en) begin
      d1.neg <= in_pow.neg;
      d1.a   <= in_pow.a;
      d1.h2  <= h2_sum[A2W-1:1];
      d2     <= d1;
      d3     <= d2;

      s_sum  <= SW'(d3.a) - SW'(q3) + SW'(q5) - SW'(q7);
      c_sum  <= ONE_Q24 - SW'(d3.h2) + SW'(q4) - SW'(q6);
      s4_neg <= d3.neg;

      s_neg  <= s4_neg ^ s_sum[SW-1];
      s_mag  <= s_sum[SW-1] ? MW'(-s_sum) : MW'(s_sum);
      c_neg  <= c_sum[SW-1];
      c_mag  <= c_sum[SW-1] ? MW'(-c_sum) : MW'(c_sum);

      out_trig.sine   <= sat_out(s_neg, s_rnd[MW-1:SHR]);
      out_trig.cosine <= sat_out(c_neg, c_rnd[MW-1:SHR]);
    end
  end

endmodule

/* rtl/taylor_sine_cosine_unit.sv */
// Taylor sine/cosine unit: top level. Depends on tsc_pkg, tsc_angle_if, tsc_trig_if,
// tsc_reduce, tsc_powers, tsc_cdiv and tsc_series.
//
// angle_ch carries one angle per beat, signed with ANGLE_FRAC_BITS fraction bits.
// trig_ch returns one beat per angle, in order: sine and cosine of the angle folded
// into [-pi, pi], from the four-term series, signed Q.16 in 18 bits, saturated.
// The path from the accepting edge to trig_ch.valid is the same for any
// ANGLE_FRAC_BITS; the beat can be taken while trig_ch.valid is high. The path has 18
// register stages: seven for the 2*pi reduction (capture, reciprocal multiply,
// quotient times 2*pi, subtract, correct, fold, round), four multiply stages, six
// division and sum stages, and a two-entry output buffer.
// Throughput is one angle per cycle while trig_ch keeps up.
// The whole pipeline advances together whenever the output buffer has room, so the
// input is still taken while one result waits; a stalled receiver holds its beat and,
// once both buffer entries are full, angle_ch.ready drops until a beat is taken.
// Synchronous reset empties the pipeline and the buffer; no beat is in flight after it.
`timescale 1ns / 1ps

module taylor_sine_cosine_unit #(
  parameter int ANGLE_FRAC_BITS = 16
) (
  input logic        clk,
  input logic        rst,
  tsc_angle_if.sink  angle_ch,
  tsc_trig_if.source trig_ch
);

  localparam logic [1:0] BUF_FULL = 2'd2;

  logic               adv;
  logic               red_vld;
  tsc_pkg::tsc_arg_t  red_arg;
  logic               pow_vld;
  tsc_pkg::tsc_pow_t  pow_data;
  logic               ser_vld;
  tsc_pkg::tsc_trig_t ser_trig;

  tsc_reduce #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_reduce (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (angle_ch.valid),
    .angle   (angle_ch.angle),
    .out_vld (red_vld),
    .out_arg (red_arg)
  );

  tsc_powers u_powers (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (red_vld),
    .in_arg  (red_arg),
    .out_vld (pow_vld),
    .out_pow (pow_data)
  );

  tsc_series u_series (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (pow_vld),
    .in_pow   (pow_data),
    .out_vld  (ser_vld),
    .out_trig (ser_trig)
  );

  tsc_pkg::tsc_trig_t obuf [2];
  logic [1:0]         cnt;
  logic [1:0]         cnt_next;
  logic               wr_ptr;
  logic               rd_ptr;
  logic               push;
  logic               pop;

  assign adv            = (cnt != BUF_FULL) || trig_ch.ready;
  assign angle_ch.ready = adv;
  assign push           = ser_vld && adv;
  assign pop            = trig_ch.valid && trig_ch.ready;
  assign cnt_next       = cnt + 2'(push) - 2'(pop);

  assign trig_ch.valid  = cnt != 2'd0;
  assign trig_ch.sine   = obuf[rd_ptr].sine;
  assign trig_ch.cosine = obuf[rd_ptr].cosine;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
    if (push) begin
      obuf[wr_ptr] <= ser_trig;
    end
  end

endmodule

/* test/taylor_sine_cosine_unit_test.sv */
// Self-checking testbench for taylor_sine_cosine_unit: drives angles with random pacing,
// predicts sine and cosine of each angle and compares every result beat in order.
// Depends on tsc_pkg, tsc_angle_if, tsc_trig_if and the unit itself.
`timescale 1ns / 1ps

module taylor_sine_cosine_unit_test;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int RST_CYCLES = 5;
  localparam int DRAIN_CYCLES = 40;
  localparam int STUCK_LIMIT = 2000;
  localparam logic signed [tsc_pkg::ANGLE_W-1:0] ANGLE_MAX = 32'sh7FFFFFFF;
  localparam logic signed [tsc_pkg::ANGLE_W-1:0] ANGLE_MIN = 32'sh80000000;
  localparam int PI_Q16 = 205887;
  localparam int PHASE_ITEMS = 330;

  logic clk = 1'b0;
  logic rst;

  tsc_angle_if angle_ch();
  tsc_trig_if trig_ch();

  taylor_sine_cosine_unit #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .angle_ch(angle_ch),
    .trig_ch(trig_ch)
  );

  tsc_pkg::tsc_trig_t pending_trig[$];
  int error_count = 0;
  int stuck_cycles = 0;
  bit src_idle = 1'b0;
  bit snk_idle = 1'b0;

  always #5 clk = ~clk;

  function automatic bit [63:0] round_mul(bit [63:0] p, bit [63:0] q);
    return (p * q + (64'd1 << (tsc_pkg::WFRAC - 1))) >> tsc_pkg::WFRAC;
  endfunction

  function automatic bit [63:0] round_div(bit [63:0] v, bit [63:0] d);
    return (v + d / 2) / d;
  endfunction

  function automatic logic signed [tsc_pkg::OUT_W-1:0] to_q16(longint v);
    longint r;
    if (v < 0) begin
      r = -((-v + 128) >>> 8);
    end else begin
      r = (v + 128) >>> 8;
    end
    if (r > 131071) r = 131071;
    if (r < -131072) r = -131072;
    return r[tsc_pkg::OUT_W-1:0];
  endfunction

  function automatic tsc_pkg::tsc_trig_t series_trig(
      logic signed [tsc_pkg::ANGLE_W-1:0] angle);
    longint pi_w, two_pi_w, x, turns, s, c;
    bit neg;
    bit [63:0] a, a2, a3, a4, a5, a6, a7;
    tsc_pkg::tsc_trig_t r;
    pi_w = longint'(tsc_pkg::PI_Q32);
    two_pi_w = longint'(tsc_pkg::TWO_PI_Q32);
    x = longint'(angle) * (64'sd1 << (32 - ANGLE_FRAC_BITS));
    if (x > pi_w) begin
      turns = (x - pi_w + two_pi_w - 1) / two_pi_w;
      x = x - turns * two_pi_w;
    end else if (x < -pi_w) begin
      turns = (-pi_w - x + two_pi_w - 1) / two_pi_w;
      x = x + turns * two_pi_w;
    end
    neg = x < 0;
    a = ((neg ? -x : x) + 128) >> 8;
    a2 = round_mul(a, a);
    a3 = round_mul(a2, a);
    a4 = round_mul(a2, a2);
    a5 = round_mul(a3, a2);
    a6 = round_mul(a4, a2);
    a7 = round_mul(a5, a2);
    s = longint'(a) - longint'(round_div(a3, tsc_pkg::DIV3))
        + longint'(round_div(a5, tsc_pkg::DIV5)) - longint'(round_div(a7, tsc_pkg::DIV7));
    c = longint'(64'd1 << tsc_pkg::WFRAC) - longint'(round_div(a2, 2))
        + longint'(round_div(a4, tsc_pkg::DIV4)) - longint'(round_div(a6, tsc_pkg::DIV6));
    if (neg) s = -s;
    r.sine = to_q16(s);
    r.cosine = to_q16(c);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [tsc_pkg::ANGLE_W-1:0] pick_angle();
    int sel;
    int turns;
    sel = $urandom_range(0, 9);
    if (sel < 3) return $urandom;
    if (sel < 6) return $urandom_range(0, 2 * PI_Q16 + 2) - (PI_Q16 + 1);
    if (sel < 8) begin
      turns = int'($urandom_range(0, 20000)) - 10000;
      return int'(turns * 3.141592653589793 * 65536.0) + int'($urandom_range(0, 6)) - 3;
    end
    if (sel == 8) return int'($urandom_range(0, 128)) - 64;
    if ($urandom_range(0, 1)) return ANGLE_MAX - $urandom_range(0, 255);
    return ANGLE_MIN + $urandom_range(0, 255);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // One beat per call; valid stays high into the next call unless a gap is taken.
  task automatic send_angle(logic signed [tsc_pkg::ANGLE_W-1:0] angle);
    angle_ch.valid <= 1'b1;
    angle_ch.angle <= angle;
    do @(posedge clk); while (angle_ch.ready !== 1'b1);
    pending_trig.push_back(series_trig(angle));
    if (src_idle && $urandom_range(0, 3) == 0) begin
      angle_ch.valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    angle_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_trig.size() != 0);
  endtask

  task automatic test_directed_angles();
    logic signed [tsc_pkg::ANGLE_W-1:0] angles[$];
    src_idle = 1'b0;
    snk_idle = 1'b0;
    angles = '{0, 1, -1, 65536, -65536, PI_Q16 / 4, PI_Q16 / 2, -PI_Q16 / 2,
               PI_Q16, PI_Q16 + 1, -PI_Q16, -PI_Q16 - 1, 2 * PI_Q16 + 1, -2 * PI_Q16 - 1,
               617662, 617663, -617662, -617663, ANGLE_MAX, ANGLE_MIN,
               32'sh55555555, 32'shAAAAAAAA};
    foreach (angles[i]) send_angle(angles[i]);
    wait_drained();
  endtask

  task automatic test_random_angles();
    for (int phase = 0; phase < 4; phase++) begin
      src_idle = phase[0];
      snk_idle = phase[1];
      repeat (PHASE_ITEMS) send_angle(pick_angle());
    end
  endtask

  task automatic test_pause_until_drained();
    src_idle = 1'b1;
    snk_idle = 1'b1;
    repeat (20) send_angle(pick_angle());
    wait_drained();
    repeat (20) send_angle(pick_angle());
  endtask

  initial begin
    rst <= 1'b1;
    angle_ch.valid <= 1'b0;
    angle_ch.angle <= '0;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_angles();
    test_random_angles();
    test_pause_until_drained();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    trig_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (snk_idle && $urandom_range(0, 3) == 0) begin
        trig_ch.ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end
      trig_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    tsc_pkg::tsc_trig_t want;
    if (!rst && trig_ch.valid === 1'b1 && trig_ch.ready === 1'b1) begin
      if (pending_trig.size() == 0) begin
        report_mismatch("unexpected beat, sine", trig_ch.sine, 0);
      end else begin
        want = pending_trig.pop_front();
        if (trig_ch.sine !== want.sine) report_mismatch("sine", trig_ch.sine, want.sine);
        if (trig_ch.cosine !== want.cosine) begin
          report_mismatch("cosine", trig_ch.cosine, want.cosine);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((angle_ch.valid === 1'b1 && angle_ch.ready === 1'b1) ||
        (trig_ch.valid === 1'b1 && trig_ch.ready === 1'b1)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule
